// ===== rtl/hyrl_pkg.sv =====
// ----------------------------------------------------------------------------
// hyrl_pkg
// Shared constants, command/status types and the CORDIC angle table for the
// heading yaw rate limiter.
// ----------------------------------------------------------------------------
package hyrl_pkg;

  localparam int TICK_HZ      = 50;
  localparam int CORDIC_STEPS = 16;

  localparam int PI_Q     = 25736;
  localparam int TWO_PI_Q = 51472;

  localparam int RECIP_SHIFT = 26;
  localparam int STEP_RECIP  = ((1 << RECIP_SHIFT) + TICK_HZ - 1) / TICK_HZ;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 17;
  localparam int MUL_OPS    = 8;

  localparam logic [2:0] CFG_GOAL_X     = 3'd0;
  localparam logic [2:0] CFG_GOAL_Y     = 3'd1;
  localparam logic [2:0] CFG_GOAL_Z     = 3'd2;
  localparam logic [2:0] CFG_MAX_RATE   = 3'd3;
  localparam logic [2:0] CFG_NEAR_DIST  = 3'd4;

  localparam logic [2:0] MUL_VX   = 3'd0;
  localparam logic [2:0] MUL_VY   = 3'd1;
  localparam logic [2:0] MUL_VZ   = 3'd2;
  localparam logic [2:0] MUL_DX   = 3'd3;
  localparam logic [2:0] MUL_DY   = 3'd4;
  localparam logic [2:0] MUL_DZ   = 3'd5;
  localparam logic [2:0] MUL_NEAR = 3'd6;
  localparam logic [2:0] MUL_STEP = 3'd7;

  localparam logic [1:0] DIV_VX = 2'd0;
  localparam logic [1:0] DIV_DX = 2'd1;
  localparam logic [1:0] DIV_VY = 2'd2;
  localparam logic [1:0] DIV_DY = 2'd3;

  typedef struct packed {
    logic       load;
    logic       mul_go;
    logic [2:0] mul_sel;
    logic       sq_init;
    logic       sq_step;
    logic       sq_store;
    logic       sq_sel;
    logic       dv_init;
    logic       dv_step;
    logic       dv_store;
    logic [1:0] dv_sel;
    logic       co_init;
    logic       co_step;
    logic [4:0] co_iter;
    logic       round;
    logic       finish;
  } hyrl_cmd_t;

  typedef struct packed {
    logic far;
    logic out_free;
  } hyrl_status_t;

  function automatic logic signed [23:0] atan_q20(input logic [4:0] i);
    logic signed [23:0] a;
    case (i)
      5'd0:    a = 24'sd823550;
      5'd1:    a = 24'sd486170;
      5'd2:    a = 24'sd256879;
      5'd3:    a = 24'sd130396;
      5'd4:    a = 24'sd65451;
      5'd5:    a = 24'sd32757;
      5'd6:    a = 24'sd16383;
      5'd7:    a = 24'sd8192;
      5'd8:    a = 24'sd4096;
      5'd9:    a = 24'sd2048;
      5'd10:   a = 24'sd1024;
      5'd11:   a = 24'sd512;
      5'd12:   a = 24'sd256;
      5'd13:   a = 24'sd128;
      5'd14:   a = 24'sd64;
      5'd15:   a = 24'sd32;
      5'd16:   a = 24'sd16;
      5'd17:   a = 24'sd8;
      5'd18:   a = 24'sd4;
      5'd19:   a = 24'sd2;
      5'd20:   a = 24'sd1;
      default: a = 24'sd0;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/hyrl_in_if.sv =====
// ----------------------------------------------------------------------------
// hyrl_in_if
// Input channel: one trajectory sample per item.
// ----------------------------------------------------------------------------
interface hyrl_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;

  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, output ready);
endinterface

// ===== rtl/hyrl_out_if.sv =====
// ----------------------------------------------------------------------------
// hyrl_out_if
// Output channel: commanded yaw and yaw rate per item.
// ----------------------------------------------------------------------------
interface hyrl_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] yaw_out;
  logic signed [15:0] yaw_rate_out;

  modport source (output valid, yaw_out, yaw_rate_out, input ready);
  modport sink (input valid, yaw_out, yaw_rate_out, output ready);
endinterface

// ===== rtl/hyrl_ctrl.sv =====
// ----------------------------------------------------------------------------
// hyrl_ctrl
// Sequencer: products, then for a far goal two square roots, four divisions and CORDIC, then round and limit.
// ----------------------------------------------------------------------------
module hyrl_ctrl
  import hyrl_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  hyrl_status_t status,
  output hyrl_cmd_t    cmd
);

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_MUL      = 14'b00000000000010,
    S_DRAIN    = 14'b00000000000100,
    S_DECIDE   = 14'b00000000001000,
    S_SQ_INIT  = 14'b00000000010000,
    S_SQ_RUN   = 14'b00000000100000,
    S_SQ_STORE = 14'b00000001000000,
    S_DV_INIT  = 14'b00000010000000,
    S_DV_RUN   = 14'b00000100000000,
    S_DV_STORE = 14'b00001000000000,
    S_CO_INIT  = 14'b00010000000000,
    S_CO_RUN   = 14'b00100000000000,
    S_ROUND    = 14'b01000000000000,
    S_LIMIT    = 14'b10000000000000
  } state_t;

  state_t     state, state_next;
  logic [4:0] cnt, cnt_next;
  logic [1:0] sub, sub_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      sub   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      sub   <= sub_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    sub_next   = sub;
    cmd        = '0;
    cmd.mul_sel = cnt[2:0];
    cmd.sq_sel  = sub[0];
    cmd.dv_sel  = sub;
    cmd.co_iter = cnt;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_go = 1'b1;
        cnt_next   = cnt + 5'd1;
        if (cnt == 5'(MUL_OPS - 1)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_DECIDE;
      S_DECIDE: begin
        sub_next   = '0;
        state_next = status.far ? S_SQ_INIT : S_ROUND;
      end
      S_SQ_INIT: begin
        cmd.sq_init = 1'b1;
        cnt_next    = '0;
        state_next  = S_SQ_RUN;
      end
      S_SQ_RUN: begin
        cmd.sq_step = 1'b1;
        cnt_next    = cnt + 5'd1;
        if (cnt == 5'(SQRT_STEPS - 1)) begin
          state_next = S_SQ_STORE;
        end
      end
      S_SQ_STORE: begin
        cmd.sq_store = 1'b1;
        if (sub[0]) begin
          sub_next   = '0;
          state_next = S_DV_INIT;
        end else begin
          sub_next   = 2'd1;
          state_next = S_SQ_INIT;
        end
      end
      S_DV_INIT: begin
        cmd.dv_init = 1'b1;
        cnt_next    = '0;
        state_next  = S_DV_RUN;
      end
      S_DV_RUN: begin
        cmd.dv_step = 1'b1;
        cnt_next    = cnt + 5'd1;
        if (cnt == 5'(DIV_STEPS - 1)) begin
          state_next = S_DV_STORE;
        end
      end
      S_DV_STORE: begin
        cmd.dv_store = 1'b1;
        sub_next     = sub + 2'd1;
        state_next   = (sub == DIV_DY) ? S_CO_INIT : S_DV_INIT;
      end
      S_CO_INIT: begin
        cmd.co_init = 1'b1;
        cnt_next    = '0;
        state_next  = S_CO_RUN;
      end
      S_CO_RUN: begin
        cmd.co_step = 1'b1;
        cnt_next    = cnt + 5'd1;
        if (cnt == 5'(CORDIC_STEPS - 1)) begin
          state_next = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.round  = 1'b1;
        state_next = S_LIMIT;
      end
      S_LIMIT: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/hyrl_dp.sv =====
// ----------------------------------------------------------------------------
// hyrl_dp
// Datapath: config registers, shared multiplier, bit-serial square root,
// restoring divider, vectoring CORDIC, yaw limiter and output register.
// ----------------------------------------------------------------------------
module hyrl_dp
  import hyrl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  hyrl_cmd_t          cmd,
  output hyrl_status_t       status,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic signed [31:0] vel_z,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [15:0] yaw_out,
  output logic signed [15:0] yaw_rate_out
);

  localparam logic signed [19:0] PI_L     = 20'(PI_Q);
  localparam logic signed [19:0] TWO_PI_L = 20'(TWO_PI_Q);

  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic [32:0] a;
    a = v[32] ? 33'(-v) : 33'(v);
    return a[31:0];
  endfunction

  function automatic logic big33(input logic signed [32:0] v);
    return (v > 33'sd2147483647) || (v < -33'sd2147483647);
  endfunction

  function automatic logic signed [32:0] half33(input logic signed [32:0] v);
    return v[32] ? ((v + 33'sd1) >>> 1) : (v >>> 1);
  endfunction

  logic signed [31:0] goal_x, goal_y, goal_z;
  logic [14:0]        max_rate;
  logic [30:0]        near_dist;

  logic signed [32:0] vx, vy, vz, dx, dy, dz;
  logic               far_big;
  logic signed [32:0] dxw, dyw, dzw;
  logic               big_w;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [2:0]  prod_sel;
  logic        prod_valid;
  logic [63:0] vsum, gsum, nsq;
  logic [15:0] step;
  logic [15:0] step_num;

  logic [63:0] sq_rad;
  logic [33:0] sq_rem, sq_rem_n, sq_trial;
  logic [31:0] sq_root;
  logic [31:0] vn, gn;

  logic signed [32:0] dv_src;
  logic [31:0]        dv_mag;
  logic [31:0]        dv_rem;
  logic [16:0]        dv_bits, dv_q;
  logic [31:0]        dv_den;
  logic               dv_neg;
  logic [32:0]        dv_rn;
  logic signed [17:0] dv_val;
  logic signed [17:0] ux_v, ux_g, uy_v, uy_g;

  logic signed [18:0] sx, sy;
  logic signed [31:0] x0, y0;
  logic signed [31:0] co_x, co_y;
  logic signed [23:0] co_z;
  logic               co_zero;
  logic signed [31:0] xs, ys;
  logic signed [23:0] rz;

  logic signed [15:0] want, prev_yaw;
  logic signed [16:0] rnd;

  logic signed [19:0] w, l, d, stp, yaw_n, rm;
  logic signed [31:0] rate_n, rate_free;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x    <= 32'sd6553600;
      goal_y    <= 32'sd0;
      goal_z    <= 32'sd131072;
      max_rate  <= 15'd7721;
      near_dist <= 31'd13107;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GOAL_X:    goal_x    <= cfg_data;
        CFG_GOAL_Y:    goal_y    <= cfg_data;
        CFG_GOAL_Z:    goal_z    <= cfg_data;
        CFG_MAX_RATE:  max_rate  <= cfg_data[14:0];
        CFG_NEAR_DIST: near_dist <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // goal offsets, halved toward zero when any component is out of range
  always_comb begin
    dxw   = 33'(goal_x) - 33'(pos_x);
    dyw   = 33'(goal_y) - 33'(pos_y);
    dzw   = 33'(goal_z) - 33'(pos_z);
    big_w = big33(dxw) || big33(dyw) || big33(dzw);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vx      <= 33'(vel_x);
      vy      <= 33'(vel_y);
      vz      <= 33'(vel_z);
      far_big <= big_w;
      dx      <= big_w ? half33(dxw) : dxw;
      dy      <= big_w ? half33(dyw) : dyw;
      dz      <= big_w ? half33(dzw) : dzw;
    end
  end

  // shared multiplier
  assign step_num = {1'b0, max_rate} + 16'(TICK_HZ / 2);

  always_comb begin
    case (cmd.mul_sel)
      MUL_VX:   begin mul_a = mag33(vx); mul_b = mul_a; end
      MUL_VY:   begin mul_a = mag33(vy); mul_b = mul_a; end
      MUL_VZ:   begin mul_a = mag33(vz); mul_b = mul_a; end
      MUL_DX:   begin mul_a = mag33(dx); mul_b = mul_a; end
      MUL_DY:   begin mul_a = mag33(dy); mul_b = mul_a; end
      MUL_DZ:   begin mul_a = mag33(dz); mul_b = mul_a; end
      MUL_NEAR: begin mul_a = {1'b0, near_dist}; mul_b = mul_a; end
      MUL_STEP: begin mul_a = {16'd0, step_num}; mul_b = 32'(STEP_RECIP); end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= cmd.mul_go;
    end
  end

  always_ff @(posedge clk) begin
    prod     <= mul_a * mul_b;
    prod_sel <= cmd.mul_sel;
    if (cmd.load) begin
      vsum <= '0;
      gsum <= '0;
    end else if (prod_valid) begin
      case (prod_sel)
        MUL_VX, MUL_VY, MUL_VZ: vsum <= vsum + prod;
        MUL_DX, MUL_DY, MUL_DZ: gsum <= gsum + prod;
        MUL_NEAR:               nsq  <= prod;
        MUL_STEP:               step <= prod[RECIP_SHIFT +: 16];
        default: ;
      endcase
    end
  end

  assign status.far = far_big || (gsum > nsq);

  // bit-serial square root
  always_comb begin
    sq_rem_n = {sq_rem[31:0], sq_rad[63:62]};
    sq_trial = {sq_root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_init) begin
      sq_rad  <= cmd.sq_sel ? gsum : vsum;
      sq_rem  <= '0;
      sq_root <= '0;
    end else if (cmd.sq_step) begin
      sq_rad <= {sq_rad[61:0], 2'b00};
      if (sq_rem_n >= sq_trial) begin
        sq_rem  <= sq_rem_n - sq_trial;
        sq_root <= {sq_root[30:0], 1'b1};
      end else begin
        sq_rem  <= sq_rem_n;
        sq_root <= {sq_root[30:0], 1'b0};
      end
    end
    if (cmd.sq_store) begin
      if (cmd.sq_sel) begin
        gn <= sq_root;
      end else begin
        vn <= sq_root;
      end
    end
  end

  // restoring divider: unit component = |c| * 2^16 / norm
  always_comb begin
    case (cmd.dv_sel)
      DIV_VX:  dv_src = vx;
      DIV_DX:  dv_src = dx;
      DIV_VY:  dv_src = vy;
      DIV_DY:  dv_src = dy;
      default: dv_src = vx;
    endcase
    dv_mag = mag33(dv_src);
    dv_rn  = {dv_rem, dv_bits[16]};
    dv_val = (dv_den == 32'd0) ? 18'sd0 :
             (dv_neg ? -$signed({1'b0, dv_q}) : $signed({1'b0, dv_q}));
  end

  always_ff @(posedge clk) begin
    if (cmd.dv_init) begin
      dv_rem  <= {1'b0, dv_mag[31:1]};
      dv_bits <= {dv_mag[0], 16'd0};
      dv_q    <= '0;
      dv_den  <= cmd.dv_sel[0] ? gn : vn;
      dv_neg  <= dv_src[32];
    end else if (cmd.dv_step) begin
      dv_bits <= {dv_bits[15:0], 1'b0};
      if (dv_rn >= {1'b0, dv_den}) begin
        dv_rem <= 32'(dv_rn - {1'b0, dv_den});
        dv_q   <= {dv_q[15:0], 1'b1};
      end else begin
        dv_rem <= dv_rn[31:0];
        dv_q   <= {dv_q[15:0], 1'b0};
      end
    end
    if (cmd.dv_store) begin
      case (cmd.dv_sel)
        DIV_VX:  ux_v <= dv_val;
        DIV_DX:  ux_g <= dv_val;
        DIV_VY:  uy_v <= dv_val;
        DIV_DY:  uy_g <= dv_val;
        default: ;
      endcase
    end
  end

  // vectoring CORDIC
  always_comb begin
    sx = 19'(ux_v) + 19'(ux_g);
    sy = 19'(uy_v) + 19'(uy_g);
    x0 = {{13{sx[18]}}, sx} <<< 10;
    y0 = {{13{sy[18]}}, sy} <<< 10;
    xs = co_x >>> cmd.co_iter;
    ys = co_y >>> cmd.co_iter;
  end

  always_ff @(posedge clk) begin
    if (cmd.co_init) begin
      co_zero <= (sx == 19'sd0) && (sy == 19'sd0);
      if (x0 < 0) begin
        if (y0 >= 0) begin
          co_x <= y0;
          co_y <= -x0;
          co_z <= atan_q20(5'd0) <<< 1;
        end else begin
          co_x <= -y0;
          co_y <= x0;
          co_z <= -(atan_q20(5'd0) <<< 1);
        end
      end else begin
        co_x <= x0;
        co_y <= y0;
        co_z <= '0;
      end
    end else if (cmd.co_step) begin
      if (co_y > 0) begin
        co_x <= co_x + ys;
        co_y <= co_y - xs;
        co_z <= co_z + atan_q20(cmd.co_iter);
      end else begin
        co_x <= co_x - ys;
        co_y <= co_y + xs;
        co_z <= co_z - atan_q20(cmd.co_iter);
      end
    end
  end

  // round to Q3.13 and clamp
  always_comb begin
    rz  = (co_z + 24'sd64) >>> 7;
    rnd = rz[16:0];
    if (rnd > 17'(PI_Q)) begin
      rnd = 17'(PI_Q);
    end else if (rnd < -17'(PI_Q)) begin
      rnd = -17'(PI_Q);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.round) begin
      if (!status.far) begin
        want <= prev_yaw;
      end else if (co_zero) begin
        want <= '0;
      end else begin
        want <= rnd[15:0];
      end
    end
  end

  // step limit with seam wrap
  always_comb begin
    w         = 20'(want);
    l         = 20'(prev_yaw);
    d         = w - l;
    stp       = {4'd0, step};
    rm        = {5'd0, max_rate};
    rate_free = 32'(d) * 32'(TICK_HZ);
    if (d > PI_L) begin
      if (d - TWO_PI_L < -stp) begin
        yaw_n = l - stp;
        if (yaw_n < -PI_L) yaw_n = yaw_n + TWO_PI_L;
      end else begin
        yaw_n = w;
      end
      rate_n = -32'(rm);
    end else if (d < -PI_L) begin
      if (d + TWO_PI_L > stp) begin
        yaw_n = l + stp;
        if (yaw_n > PI_L) yaw_n = yaw_n - TWO_PI_L;
      end else begin
        yaw_n = w;
      end
      rate_n = 32'(rm);
    end else if (d < -stp) begin
      yaw_n = l - stp;
      if (yaw_n < -PI_L) yaw_n = yaw_n + TWO_PI_L;
      rate_n = -32'(rm);
    end else if (d > stp) begin
      yaw_n = l + stp;
      if (yaw_n > PI_L) yaw_n = yaw_n - TWO_PI_L;
      rate_n = 32'(rm);
    end else begin
      yaw_n  = w;
      rate_n = rate_free;
    end
    if (rate_n > 32'sd32767) begin
      rate_n = 32'sd32767;
    end else if (rate_n < -32'sd32768) begin
      rate_n = -32'sd32768;
    end
  end

  // output register and yaw state
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      prev_yaw  <= '0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
      prev_yaw  <= yaw_n[15:0];
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      yaw_out      <= yaw_n[15:0];
      yaw_rate_out <= rate_n[15:0];
    end
  end

endmodule

// ===== rtl/heading_yaw_rate_limiter.sv =====
// The near-goal path runs the eight products on one multiplier, then round
// and limit; a far goal also takes two 32-step square roots, four 17-step
// divisions and 16 CORDIC steps before the round and limit.
// Throughput: one item at a time; the next item is taken once the result is
// in the output register, which holds it until taken.
// Reset (synchronous, active high) restores the register defaults and yaw 0.
// ----------------------------------------------------------------------------
// heading_yaw_rate_limiter
// Wanted yaw from velocity and goal direction, rate limited with wrap.
// ----------------------------------------------------------------------------
module heading_yaw_rate_limiter
  import hyrl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  hyrl_in_if.sink     in_ch,
  hyrl_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  hyrl_cmd_t    cmd;
  hyrl_status_t status;

  hyrl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  hyrl_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pos_x        (in_ch.pos_x),
    .pos_y        (in_ch.pos_y),
    .pos_z        (in_ch.pos_z),
    .vel_x        (in_ch.vel_x),
    .vel_y        (in_ch.vel_y),
    .vel_z        (in_ch.vel_z),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .yaw_out      (out_ch.yaw_out),
    .yaw_rate_out (out_ch.yaw_rate_out)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken while busy");

  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.yaw_out <= 16'sd25736) && (out_ch.yaw_out >= -16'sd25736))
    else $error("yaw out of range");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(cmd.finish))
    else $error("result without finish");

  a_finish_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> status.out_free)
    else $error("result overwritten");
`endif

endmodule
